// ===== design/fpbc_pkg.sv =====
package fpbc_pkg;
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_PROBES  = 8;
  localparam int KEY_W   = 64;
  localparam int TOTAL_W = 63;
  localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;
endpackage

// ===== design/flow_pair_byte_counter.sv =====
// Flow: the S_HASH state waits for the registered hash after the accepting
// edge, then each probe slot takes S_RD (read) and S_CMP (compare/write back),
// 1 to MAX_PROBES probes; the result is valid next, in S_OUT. Items are taken
// one at a time: in_stall stays high until the result leaves S_OUT.
// Reset: synchronous, active low; a clearing pass over all TABLE_DEPTH slots
// zeroes the valid memory and holds in_stall high meanwhile.
module flow_pair_byte_counter #(
  parameter int TABLE_DEPTH = fpbc_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_PROBES  = fpbc_pkg::DEF_MAX_PROBES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [15:0] in_ip_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [62:0] out_byte_total,
  output logic        out_found,
  output logic        out_table_full
);
  import fpbc_pkg::*;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PRB_W = $clog2(MAX_PROBES + 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r;
  logic [IDX_W-1:0] clr_r, slot_r;
  logic [1:0] hcnt_r;
  logic [PRB_W-1:0] prb_r;
  logic op_r;
  logic [KEY_W-1:0] key_r;
  logic [15:0] len_r;
  logic [IDX_W-1:0] home;

  logic mem_v [TABLE_DEPTH];
  logic [KEY_W-1:0] mem_k [TABLE_DEPTH];
  logic [TOTAL_W-1:0] mem_t [TABLE_DEPTH];
  logic rd_v_r;
  logic [KEY_W-1:0] rd_k_r;
  logic [TOTAL_W-1:0] rd_t_r;

  fpbc_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
    .clk(clk), .key(key_r), .home(home)
  );

  logic hit, empty, wr_en;
  logic [TOTAL_W-1:0] base, sum_sat;
  logic [TOTAL_W:0] sum;
  assign hit   = rd_v_r && (rd_k_r == key_r);
  assign empty = !rd_v_r;
  assign base  = hit ? rd_t_r : '0;
  assign sum   = {1'b0, base} + (TOTAL_W + 1)'(len_r);
  assign sum_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign wr_en = (state_r == S_CMP) && (op_r == OP_ADD) && (hit || empty);

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      mem_v[clr_r] <= 1'b0;
    end else if (wr_en) begin
      mem_v[slot_r] <= 1'b1;
      mem_k[slot_r] <= key_r;
      mem_t[slot_r] <= sum_sat;
    end
    rd_v_r <= mem_v[slot_r];
    rd_k_r <= mem_k[slot_r];
    rd_t_r <= mem_t[slot_r];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IDX_W'(TABLE_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          op_r   <= in_opcode;
          key_r  <= {in_src_ip, in_dst_ip};
          len_r  <= in_ip_len;
          hcnt_r <= '0;
          prb_r  <= '0;
          state_r <= S_HASH;
        end
        S_HASH: begin
          hcnt_r <= hcnt_r + 1'b1;
          if (hcnt_r == 2'd3) begin
            slot_r  <= home;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (hit || empty) begin
            out_found      <= hit;
            out_table_full <= 1'b0;
            out_byte_total <= (op_r == OP_ADD) ? sum_sat : base;
            state_r <= S_OUT;
          end else if (prb_r == PRB_W'(MAX_PROBES - 1)) begin
            out_found      <= 1'b0;
            out_table_full <= (op_r == OP_ADD);
            out_byte_total <= '0;
            state_r <= S_OUT;
          end else begin
            prb_r   <= prb_r + 1'b1;
            slot_r  <= (slot_r == IDX_W'(TABLE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_CLR;
      endcase
    end
  end
endmodule

// ===== design/fpbc_hash.sv =====
// Home-slot hash: 32x32 partial products, sum and reciprocal quotient are
// registered, then the remainder is formed combinationally.
module fpbc_hash #(
  parameter int TABLE_DEPTH = fpbc_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic [fpbc_pkg::KEY_W-1:0]     key,
  output logic [$clog2(TABLE_DEPTH)-1:0] home
);
  import fpbc_pkg::*;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [31:0] MUL_LO = HASH_MUL[31:0];
  localparam logic [31:0] MUL_HI = HASH_MUL[63:32];
  // floor(x / depth) == (x * RECIP) >> SH for every 32-bit x
  localparam int SH = 32 + IDX_W;
  localparam logic [33:0] RECIP =
    34'(((64'd1 << SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
  localparam logic [IDX_W-1:0] DEPTH_LO = IDX_W'(TABLE_DEPTH);

  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;
  logic [31:0] hi_r;
  logic [31:0] hi_d_r;
  logic [31:0] q_r;
  logic [65:0] qprod;
  logic [IDX_W-1:0] qd_lo;

  assign qprod = hi_r * RECIP;

  always_ff @(posedge clk) begin
    ll_r <= key[31:0] * MUL_LO;
    lh_r <= 32'(key[31:0] * MUL_HI);
    hl_r <= 32'(key[63:32] * MUL_LO);
    hi_r <= ll_r[63:32] + lh_r + hl_r;
    hi_d_r <= hi_r;
    q_r <= 32'(qprod >> SH);
  end

  // remainder is below depth, so only the low index bits are needed
  assign qd_lo = q_r[IDX_W-1:0] * DEPTH_LO;
  assign home  = hi_d_r[IDX_W-1:0] - qd_lo;
endmodule

// ===== design/fpbc_checker.sv =====
module fpbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [62:0] out_byte_total,
  input logic        out_found,
  input logic        out_table_full
);
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_found && out_byte_total == '0)
    else $error("full result carries data");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_total))
    else $error("stalled result changed");
  a_no_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid) else $error("result too early");
endmodule

bind flow_pair_byte_counter fpbc_checker u_chk (.*);

// ===== sim/flow_pair_byte_counter_tb.sv =====
`timescale 1ns / 100ps

module flow_pair_byte_counter_tb;
  import fpbc_pkg::*;

  localparam int DEPTH   = DEF_TABLE_DEPTH;
  localparam int PROBES  = DEF_MAX_PROBES;
  localparam int N_RAND  = 450;
  localparam int N_POOL  = 48;
  localparam int N_CLUS  = PROBES + 1;
  localparam logic [62:0] TOTAL_MAX = {63{1'b1}};

  typedef struct {
    logic        op;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] len;
    bit          typed;
    logic [62:0] x_total;
    logic        x_found;
    logic        x_full;
  } flow_row_t;

  typedef struct {
    logic [62:0] total;
    logic        found;
    logic        full;
  } flow_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [31:0] in_src_ip;
  logic [31:0] in_dst_ip;
  logic [15:0] in_ip_len;
  logic        out_valid;
  logic        out_stall;
  logic [62:0] out_byte_total;
  logic        out_found;
  logic        out_table_full;

  // flow table shadow
  bit          slot_used [DEPTH];
  logic [63:0] slot_key [DEPTH];
  logic [62:0] slot_total [DEPTH];

  flow_result_t pending_totals[$];
  flow_row_t    directed[$];
  logic [63:0]  key_pool [N_POOL];
  logic [63:0]  clus_keys [N_CLUS];
  int           err_count;
  bit           quiet;

  flow_pair_byte_counter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_src_ip(in_src_ip), .in_dst_ip(in_dst_ip),
    .in_ip_len(in_ip_len),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte_total(out_byte_total), .out_found(out_found),
    .out_table_full(out_table_full)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int home_of(logic [63:0] key);
    logic [63:0] m;
    m = key * HASH_MUL;
    return int'(m[63:32] % DEPTH);
  endfunction

  function automatic flow_result_t update_flow_table(logic op, logic [31:0] src,
                                                      logic [31:0] dst, logic [15:0] len);
    flow_result_t r;
    logic [63:0]  key;
    logic [63:0]  sum;
    int           slot;
    int           s;
    bit           hit;
    key = {src, dst};
    r = '{total: '0, found: 1'b0, full: 1'b0};
    slot = -1;
    hit = 0;
    for (int i = 0; i < PROBES; i++) begin
      s = (home_of(key) + i) % DEPTH;
      if (!slot_used[s]) begin
        slot = s;
        break;
      end
      if (slot_key[s] == key) begin
        slot = s;
        hit = 1;
        break;
      end
    end
    if (op == OP_ADD) begin
      if (slot < 0) begin
        r.full = 1'b1;
      end else begin
        if (hit) begin
          r.found = 1'b1;
        end else begin
          slot_used[slot] = 1;
          slot_key[slot] = key;
          slot_total[slot] = '0;
        end
        sum = {1'b0, slot_total[slot]} + len;
        r.total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[62:0];
        slot_total[slot] = r.total;
      end
    end else if (hit) begin
      r.found = 1'b1;
      r.total = slot_total[slot];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [62:0] got, logic [62:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic send_flow(flow_row_t row);
    flow_result_t r;
    if (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= row.op;
    in_src_ip <= row.src;
    in_dst_ip <= row.dst;
    in_ip_len <= row.len;
    do @(posedge clk); while (in_stall);
    r = update_flow_table(row.op, row.src, row.dst, row.len);
    if (row.typed) begin
      r = '{total: row.x_total, found: row.x_found, full: row.x_full};
    end
    pending_totals.push_back(r);
  endtask

  function automatic flow_row_t mk_row(logic op, logic [63:0] key, logic [15:0] len);
    return '{op: op, src: key[63:32], dst: key[31:0], len: len, typed: 0,
             x_total: '0, x_found: 1'b0, x_full: 1'b0};
  endfunction

  // result side: random stall and in-order compare
  always @(posedge clk) begin
    flow_result_t want;
    if (out_valid && !out_stall) begin
      if (pending_totals.size() == 0) begin
        report_mismatch("unexpected item", out_byte_total, '0);
      end else begin
        want = pending_totals.pop_front();
        if (out_byte_total !== want.total)
          report_mismatch("byte_total", out_byte_total, want.total);
        if (out_found !== want.found)
          report_mismatch("found", 63'(out_found), 63'(want.found));
        if (out_table_full !== want.full)
          report_mismatch("table_full", 63'(out_table_full), 63'(want.full));
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < 30);
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    flow_row_t   row;
    logic [63:0] key;
    int          home;
    int          n;
    int          pick;
    err_count = 0;
    quiet = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_ADD;
    in_src_ip = '0;
    in_dst_ip = '0;
    in_ip_len = '0;
    out_stall = 1'b0;

    // keys that all share one home slot, one more than the probe window
    key = {$urandom, $urandom};
    home = home_of(key);
    clus_keys[0] = key;
    n = 1;
    while (n < N_CLUS) begin
      key = {$urandom, $urandom};
      if (home_of(key) == home) begin
        clus_keys[n] = key;
        n++;
      end
    end
    for (int i = 0; i < N_POOL; i++) key_pool[i] = {$urandom, $urandom};

    // directed table: empty query, probe window fill, full drop, field extremes
    row = mk_row(OP_QUERY, {$urandom, $urandom}, 16'hFFFF);
    row.typed = 1;
    directed.push_back(row);
    for (int i = 0; i < N_CLUS; i++) begin
      row = mk_row(OP_ADD, clus_keys[i], 16'(100 + i));
      row.typed = 1;
      row.x_total = (i < PROBES) ? 63'(100 + i) : '0;
      row.x_full = (i == PROBES);
      directed.push_back(row);
    end
    row = mk_row(OP_QUERY, clus_keys[PROBES], '0);
    row.typed = 1;
    directed.push_back(row);
    row = mk_row(OP_QUERY, clus_keys[0], '0);
    row.typed = 1;
    row.x_total = 63'd100;
    row.x_found = 1'b1;
    directed.push_back(row);
    directed.push_back(mk_row(OP_ADD, {64{1'b1}}, 16'hFFFF));
    directed.push_back(mk_row(OP_ADD, {64{1'b1}}, 16'hFFFF));
    directed.push_back(mk_row(OP_QUERY, {64{1'b1}}, '0));
    directed.push_back(mk_row(OP_ADD, '0, '0));
    directed.push_back(mk_row(OP_QUERY, '0, 16'hFFFF));
    directed.push_back(mk_row(OP_ADD, {32'hFFFF_FFFF, 32'h0}, 16'h8000));
    directed.push_back(mk_row(OP_ADD, {32'h0, 32'hFFFF_FFFF}, 16'h0001));
    directed.push_back(mk_row(OP_ADD, clus_keys[3], 16'hFFFF));
    directed.push_back(mk_row(OP_QUERY, clus_keys[3], '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_flow(directed[i]);

    for (int i = 0; i < N_RAND; i++) begin
      quiet = (i >= 250 && i < 350);
      if (i == 150) begin
        in_valid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 60) key = key_pool[$urandom_range(N_POOL - 1)];
      else if (pick < 75) key = clus_keys[$urandom_range(N_CLUS - 1)];
      else key = {$urandom, $urandom};
      row = mk_row(($urandom_range(99) < 35) ? OP_QUERY : OP_ADD, key, 16'($urandom));
      if ($urandom_range(9) == 0) row.len = $urandom_range(1) ? 16'hFFFF : 16'h0;
      send_flow(row);
    end
    in_valid <= 1'b0;
    quiet = 0;

    while (pending_totals.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
